FILE: src/checksummed_record_packet_deframer_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef CHECKSUMMED_RECORD_PACKET_DEFRAMER_CORE_MACROS_SVH
`define CHECKSUMMED_RECORD_PACKET_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define CRPD_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define CRPD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: src/crpd_pkg.sv
package crpd_pkg;

    // Sizes
    localparam int MAX_PACKET_DEF = 128;
    localparam int POS_W          = 8;
    localparam int ID_LIMIT_W     = 17;
    localparam int REC_W          = 48;
    localparam int TDATA_W        = 56;
    localparam int TUSER_W        = 2;

    // Framing
    localparam logic [7:0]       SYNC_BYTE     = 8'hFF;
    localparam logic [POS_W-1:0] POS_HUNT      = 8'd0;
    localparam logic [POS_W-1:0] POS_SYNC2     = 8'd1;
    localparam logic [POS_W-1:0] POS_MSG       = 8'd2;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 8'd3;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 8'd4;
    localparam logic [POS_W-1:0] PAYLOAD_START = 8'd5;
    localparam logic [POS_W-1:0] MIN_LENGTH    = 8'd6;
    // Shortest packet that holds one whole record
    localparam logic [POS_W-1:0] MIN_REC_LENGTH = 8'd12;
    localparam logic [2:0]       REC_LAST_BYTE  = 3'd5;

    localparam logic [ID_LIMIT_W-1:0] ID_LIMIT_RESET = 17'h10000;

    // Message ids
    localparam logic [7:0] MSG_RECORDS  = 8'd1;
    localparam logic [7:0] MSG_SEND_ALL = 8'd2;

    // Result kinds
    localparam logic [TUSER_W-1:0] KIND_DATA     = 2'd0;
    localparam logic [TUSER_W-1:0] KIND_ACCEPT   = 2'd1;
    localparam logic [TUSER_W-1:0] KIND_SEND_ALL = 2'd2;
    localparam logic [TUSER_W-1:0] KIND_RESEND   = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic rx_ready;
        logic rec_shift;
        logic rec_put;
        logic stat_put;
    } crpd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic final_byte;
        logic walk;
        logic rec_done;
        logic rec_pass;
        logic rec_more;
        logic out_free;
    } crpd_status_t;

endpackage

FILE: src/checksummed_record_packet_deframer_core.sv
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata = rx_byte
// m_*       out        m_tvalid/m_tready  m_tdata, m_tuser = kind, m_tlast = last of run
// cfg_*     in         cfg_valid/cfg_ready cfg_data = id_limit
//
// Header, id, length and payload bytes are taken one per cycle while s_tready is high.
// After the final byte, input stalls while the buffer is walked: each stored byte is read
// (S_RD, single registered read port) and shifted in (S_SHIFT), each record is handed
// over in S_PUT, then the status in S_STAT, waiting on m_tready while the output is full.
// rst_n clears the framing state, id_limit and the output valid; the buffer is not cleared.
// The output register lets a pending result wait while new bytes are taken.
module checksummed_record_packet_deframer_core
    import crpd_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [15:0] record_id, [47:16] record_value,
                                             // [55:48] message_id
    output logic [TUSER_W-1:0]    m_tuser,   // [1:0] result_kind
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [ID_LIMIT_W-1:0] cfg_data
);

    crpd_cmd_t    cmd;
    crpd_status_t stat;

    assign s_tready  = cmd.rx_ready;
    assign cfg_ready = 1'b1;

    crpd_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    crpd_datapath #(
        .MAX_PACKET (MAX_PACKET)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: src/crpd_datapath.sv
module crpd_datapath
    import crpd_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic [7:0]            s_tdata,
    input  logic                  cfg_valid,
    input  logic [ID_LIMIT_W-1:0] cfg_data,
    input  crpd_cmd_t             cmd,
    output crpd_status_t          stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,
    output logic [TUSER_W-1:0]    m_tuser,
    output logic                  m_tlast
);

    localparam int               AW      = $clog2(MAX_PACKET);
    localparam logic [POS_W-1:0] MAX_LEN = POS_W'(MAX_PACKET);

    logic [7:0] mem [MAX_PACKET];

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [7:0]            sum_reg, sum_next;
    logic [7:0]            msg_reg, msg_next;
    logic [POS_W-1:0]      len_reg, len_next;
    logic [ID_LIMIT_W-1:0] id_limit_reg;
    logic [TUSER_W-1:0]    kind_reg;
    logic [POS_W-1:0]      ptr_reg;
    logic [2:0]            cnt_reg;
    logic [REC_W-1:0]      rec_reg;
    logic [7:0]            rd_data_reg;
    logic                  m_tvalid_reg;
    logic [TDATA_W-1:0]    m_tdata_reg;
    logic [TUSER_W-1:0]    m_tuser_reg;
    logic                  m_tlast_reg;

    logic                  rx_fire;
    logic                  mem_we;
    logic                  final_byte;
    logic                  sum_ok;
    logic [TUSER_W-1:0]    kind_next;
    logic [POS_W-1:0]      pos_inc;
    logic [POS_W:0]        ptr_ext;

    assign rx_fire = s_tvalid & cmd.rx_ready;
    assign pos_inc = pos_reg + 8'd1;
    assign sum_ok  = (sum_reg == s_tdata);
    assign ptr_ext = {1'b0, ptr_reg};

    // Walk the framing positions for one received byte
    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        msg_next   = msg_reg;
        len_next   = len_reg;
        mem_we     = 1'b0;
        final_byte = 1'b0;
        if (rx_fire)
        begin
            unique case (pos_reg)
                POS_HUNT:
                begin
                    if (s_tdata == SYNC_BYTE)
                    begin
                        sum_next = s_tdata;
                        msg_next = 8'd0;
                        len_next = '0;
                        pos_next = POS_SYNC2;
                    end
                end
                POS_SYNC2:
                begin
                    if (s_tdata == SYNC_BYTE)
                    begin
                        sum_next = sum_reg + s_tdata;
                        pos_next = POS_MSG;
                    end
                    else
                    begin
                        pos_next = POS_HUNT;
                    end
                end
                POS_MSG:
                begin
                    msg_next = s_tdata;
                    sum_next = sum_reg + s_tdata;
                    pos_next = POS_LEN_LO;
                end
                POS_LEN_LO:
                begin
                    len_next = s_tdata;
                    sum_next = sum_reg + s_tdata;
                    pos_next = POS_LEN_HI;
                end
                POS_LEN_HI:
                begin
                    // Drop the frame on a length out of range
                    if (s_tdata != 8'd0 || len_reg < MIN_LENGTH || len_reg > MAX_LEN)
                    begin
                        pos_next = POS_HUNT;
                    end
                    else
                    begin
                        sum_next = sum_reg + s_tdata;
                        pos_next = PAYLOAD_START;
                    end
                end
                default:
                begin
                    if (pos_reg >= len_reg || pos_reg >= MAX_LEN)
                    begin
                        pos_next = POS_HUNT;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (pos_inc == len_reg)
                        begin
                            final_byte = 1'b1;
                            pos_next   = POS_HUNT;
                        end
                        else
                        begin
                            sum_next = sum_reg + s_tdata;
                            pos_next = (pos_inc >= MAX_LEN) ? POS_HUNT : pos_inc;
                        end
                    end
                end
            endcase
        end
    end

    // Pick the status kind from the checksum and message id
    always_comb
    begin
        if (!sum_ok)
        begin
            kind_next = KIND_RESEND;
        end
        else if (msg_reg == MSG_SEND_ALL)
        begin
            kind_next = KIND_SEND_ALL;
        end
        else
        begin
            kind_next = KIND_ACCEPT;
        end
    end

    assign stat.final_byte = final_byte;
    assign stat.walk       = sum_ok && (msg_reg == MSG_RECORDS) && (len_reg >= MIN_REC_LENGTH);
    assign stat.rec_done   = (cnt_reg == REC_LAST_BYTE);
    assign stat.rec_pass   = ({1'b0, rec_reg[15:0]} < id_limit_reg);
    assign stat.rec_more   = (ptr_ext + 9'd7 <= {1'b0, len_reg});
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_HUNT;
            sum_reg      <= 8'd0;
            msg_reg      <= 8'd0;
            len_reg      <= '0;
            id_limit_reg <= ID_LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            msg_reg <= msg_next;
            len_reg <= len_next;
            if (cfg_valid)
            begin
                id_limit_reg <= cfg_data;
            end
            if (cmd.rec_put || cmd.stat_put)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Packet buffer with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg[AW-1:0]] <= s_tdata;
        end
        rd_data_reg <= mem[ptr_reg[AW-1:0]];
    end

    // Record assembly and output payload
    always_ff @(posedge clk)
    begin
        if (final_byte)
        begin
            kind_reg <= kind_next;
            ptr_reg  <= PAYLOAD_START;
            cnt_reg  <= 3'd0;
        end
        else if (cmd.rec_shift)
        begin
            rec_reg <= {rd_data_reg, rec_reg[REC_W-1:8]};
            ptr_reg <= ptr_reg + 8'd1;
            cnt_reg <= (cnt_reg == REC_LAST_BYTE) ? 3'd0 : cnt_reg + 3'd1;
        end
        if (cmd.rec_put)
        begin
            m_tdata_reg <= {msg_reg, rec_reg};
            m_tuser_reg <= KIND_DATA;
            m_tlast_reg <= 1'b0;
        end
        else if (cmd.stat_put)
        begin
            m_tdata_reg <= {msg_reg, {REC_W{1'b0}}};
            m_tuser_reg <= kind_reg;
            m_tlast_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: src/crpd_controller.sv
module crpd_controller
    import crpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  crpd_status_t stat,
    output crpd_cmd_t    cmd
);

    localparam logic [2:0] S_RX    = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_STAT  = 3'd4;

    logic [2:0] state_reg, state_next;

    // Sequence receive, buffer walk and result output
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            S_RX:
            begin
                cmd.rx_ready = 1'b1;
                if (stat.final_byte)
                begin
                    state_next = stat.walk ? S_RD : S_STAT;
                end
            end
            S_RD:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.rec_shift = 1'b1;
                state_next    = stat.rec_done ? S_PUT : S_RD;
            end
            S_PUT:
            begin
                if (!stat.rec_pass || stat.out_free)
                begin
                    cmd.rec_put = stat.rec_pass;
                    state_next  = stat.rec_more ? S_RD : S_STAT;
                end
            end
            S_STAT:
            begin
                if (stat.out_free)
                begin
                    cmd.stat_put = 1'b1;
                    state_next   = S_RX;
                end
            end
            default:
            begin
                state_next = S_RX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/crpd_checker.sv
`include "checksummed_record_packet_deframer_core_macros.svh"

module crpd_checker
    import crpd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [TUSER_W-1:0] m_tuser,
    input logic               m_tlast
);

    // Hold a stalled result request
    `CRPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // Records are never last and input waits while one is pending
    `CRPD_ASSERT_IMP(a_rec_stall, m_tvalid && m_tuser == KIND_DATA, !m_tlast && !s_tready, "record with last set or input open")

    // Status items close the run and carry no record
    `CRPD_ASSERT_IMP(a_stat_form, m_tvalid && m_tuser != KIND_DATA, m_tlast && m_tdata[47:0] == 48'd0, "malformed status item")

endmodule

bind checksummed_record_packet_deframer_core crpd_checker u_crpd_checker (.*);
